/* design/omws_pkg.sv */
// ----------------------------------------------------------------------------
// omws_pkg
// Shared types, codes and helper functions of the 1-Wire bus master sequencer.
// ----------------------------------------------------------------------------
package omws_pkg;

	localparam int NUM_BUSES  = 3;
	localparam int TIMER_BITS = 16;
	localparam int RX_BYTES   = 9;
	localparam int CRC_BYTES  = 8;
	localparam int TREG_BITS  = 48;
	localparam int FIELD_BITS = 16;

	localparam logic [7:0] CRC_POLY = 8'h8C;

	localparam logic [7:0] CMD_ADDR_MATCH = 8'h55;
	localparam logic [7:0] CMD_READ_PAD   = 8'hBE;
	localparam logic [7:0] CMD_ADDR_SKIP  = 8'hCC;
	localparam logic [7:0] CMD_START_CONV = 8'h44;
	localparam logic [7:0] CMD_ADDR_READ  = 8'h33;

	// input item modes
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_READ_T   = 2'd1;
	localparam logic [1:0] MODE_CONVERT  = 2'd2;
	localparam logic [1:0] MODE_READ_ROM = 2'd3;

	// start status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNKNOWN  = 2'd1;
	localparam logic [1:0] ST_BUSY     = 2'd2;
	localparam logic [1:0] ST_NO_START = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_RESET_TIMING = 2'd0;
	localparam logic [1:0] REG_WRITE_TIMING = 2'd1;
	localparam logic [1:0] REG_READ_TIMING  = 2'd2;
	localparam logic [1:0] REG_BUS_MASK     = 2'd3;

	typedef struct packed {
		logic [TREG_BITS-1:0] reset_timing;
		logic [TREG_BITS-1:0] write_timing;
		logic [TREG_BITS-1:0] read_timing;
		logic [NUM_BUSES-1:0] bus_mask;
	} cfg_t;

	typedef struct packed {
		logic               line_release;
		logic [1:0]         active_bus;
		logic               busy_res;
		logic [1:0]         start_status;
		logic               transfer_done;
		logic               device_present;
		logic               last_result;
		logic signed [15:0] temperature_decidegrees;
		logic               temperature_valid;
		logic [63:0]        rom_code;
	} result_t;

	function automatic logic [TIMER_BITS-1:0] timing_field(
		input logic [TREG_BITS-1:0] treg,
		input logic [1:0]           s
	);
		logic [FIELD_BITS-1:0] f;
		unique case (s)
			2'd1:    f = treg[2*FIELD_BITS-1:FIELD_BITS];
			2'd2:    f = treg[3*FIELD_BITS-1:2*FIELD_BITS];
			default: f = treg[FIELD_BITS-1:0];
		endcase
		return f[TIMER_BITS-1:0];
	endfunction

	function automatic logic [3:0] send_len(input logic [1:0] kind);
		logic [3:0] n;
		unique case (kind)
			MODE_READ_T:  n = 4'd10;
			MODE_CONVERT: n = 4'd2;
			default:      n = 4'd1;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] recv_len(input logic [1:0] kind);
		logic [3:0] n;
		unique case (kind)
			MODE_READ_T:  n = 4'd9;
			MODE_CONVERT: n = 4'd0;
			default:      n = 4'd8;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] send_byte(
		input logic [1:0]  kind,
		input logic [63:0] rom,
		input logic [3:0]  idx
	);
		logic [7:0] b;
		logic [3:0] k;
		k = idx - 4'd1;
		b = 8'hFF;
		unique case (kind)
			MODE_READ_T: begin
				if (idx == 4'd0)
					b = CMD_ADDR_MATCH;
				else if (idx == 4'd9)
					b = CMD_READ_PAD;
				else if (idx < 4'd9)
					b = rom[{k[2:0], 3'b000} +: 8];
			end
			MODE_CONVERT: begin
				if (idx == 4'd0)
					b = CMD_ADDR_SKIP;
				else if (idx == 4'd1)
					b = CMD_START_CONV;
			end
			default: begin
				if (idx == 4'd0)
					b = CMD_ADDR_READ;
			end
		endcase
		return b;
	endfunction

	function automatic logic [7:0] crc_bit(input logic [7:0] crc, input logic din);
		logic [7:0] c;
		c = {1'b0, crc[7:1]};
		if (crc[0] ^ din)
			c = c ^ CRC_POLY;
		return c;
	endfunction

endpackage

/* design/omws_in_if.sv */
// ----------------------------------------------------------------------------
// omws_in_if
// Input channel of the sequencer: tick and start items.
// ----------------------------------------------------------------------------
interface omws_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [1:0]  bus_id;
	logic        line_level;
	logic [63:0] device_rom;

	modport source (output valid, mode, bus_id, line_level, device_rom, input ready);
	modport sink (input valid, mode, bus_id, line_level, device_rom, output ready);
endinterface

/* design/omws_out_if.sv */
// ----------------------------------------------------------------------------
// omws_out_if
// Result channel of the sequencer: one beat per accepted item.
// ----------------------------------------------------------------------------
interface omws_out_if;
	logic               valid;
	logic               ready;
	logic               line_release;
	logic [1:0]         active_bus;
	logic               busy_res;
	logic [1:0]         start_status;
	logic               transfer_done;
	logic               device_present;
	logic               last_result;
	logic signed [15:0] temperature_decidegrees;
	logic               temperature_valid;
	logic [63:0]        rom_code;

	modport source (
		output valid, line_release, active_bus, busy_res, start_status, transfer_done,
			device_present, last_result, temperature_decidegrees, temperature_valid,
			rom_code,
		input ready
	);
	modport sink (
		input valid, line_release, active_bus, busy_res, start_status, transfer_done,
			device_present, last_result, temperature_decidegrees, temperature_valid,
			rom_code,
		output ready
	);
endinterface

/* design/omws_cfg.sv */
// ----------------------------------------------------------------------------
// omws_cfg
// Configuration registers: slot timings and bus enable mask.
// ----------------------------------------------------------------------------
module omws_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [1:0]                          wr_index,
	input  logic [omws_pkg::TREG_BITS-1:0]      wr_data,
	output omws_pkg::cfg_t                      cfg
);
	import omws_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_timing <= TREG_BITS'(48'd17609411793600);
			cfg_q.write_timing <= TREG_BITS'(48'd429532119100);
			cfg_q.read_timing  <= TREG_BITS'(48'd2362237911100);
			cfg_q.bus_mask     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_RESET_TIMING: cfg_q.reset_timing <= wr_data;
				REG_WRITE_TIMING: cfg_q.write_timing <= wr_data;
				REG_READ_TIMING:  cfg_q.read_timing  <= wr_data;
				REG_BUS_MASK:     cfg_q.bus_mask     <= wr_data[NUM_BUSES-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/omws_core.sv */
// ----------------------------------------------------------------------------
// omws_core
// Sequencer state and the per-item step: presence reset, write and read
// slots, bitwise CRC-8 and temperature scaling.
// ----------------------------------------------------------------------------
module omws_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [1:0]             mode,
	input  logic [1:0]             bus_id,
	input  logic                   line_level,
	input  logic [63:0]            device_rom,
	input  omws_pkg::cfg_t         cfg,
	output omws_pkg::result_t      rsp
);
	import omws_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_RESET = 2'd1;
	localparam logic [1:0] PH_WRITE = 2'd2;
	localparam logic [1:0] PH_READ  = 2'd3;

	localparam int RX_W = 8 * RX_BYTES;

	logic [1:0]            phase_q, phase_d;
	logic [1:0]            stage_q, stage_d;
	logic [2:0]            bit_q, bit_d;
	logic [3:0]            byte_q, byte_d;
	logic [TIMER_BITS-1:0] cnt_q, cnt_d;
	logic [1:0]            kind_q, kind_d;
	logic [63:0]           tx_rom_q, tx_rom_d;
	logic [RX_W-1:0]       rx_q, rx_d;
	logic [7:0]            crc_q, crc_d;
	logic                  pres_q, pres_d;
	logic [1:0]            bus_q, bus_d;
	logic [63:0]           srom_q, srom_d;
	logic [15:0]           temp_q, temp_d;
	logic                  tok_q, tok_d;
	logic                  res_q, res_d;

	logic [1:0]            status;
	logic                  done;
	logic [3:0]            mask4;
	logic [1:0]            s;
	logic                  last;
	logic [TIMER_BITS-1:0] field;
	logic [3:0]            byte_inc;
	logic                  wrap;
	logic [6:0]            rx_pos;
	logic                  finish;
	logic signed [15:0]    raw;
	logic signed [19:0]    p10, pb;
	logic [15:0]           t_scaled;
	logic [7:0]            tx_byte;

	assign mask4 = 4'(cfg.bus_mask);
	assign s     = (stage_q == 2'd3) ? 2'd0 : stage_q;
	assign last  = (s == 2'd2);

	always_comb begin
		unique case (phase_q)
			PH_RESET: field = timing_field(cfg.reset_timing, s);
			PH_WRITE: field = timing_field(cfg.write_timing, s);
			default:  field = timing_field(cfg.read_timing, s);
		endcase
	end

	assign byte_inc = byte_q + 4'd1;
	assign wrap     = (bit_q == 3'd7);
	assign rx_pos   = {byte_q, bit_q};

	always_comb begin
		phase_d  = phase_q;
		stage_d  = stage_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		cnt_d    = cnt_q;
		kind_d   = kind_q;
		tx_rom_d = tx_rom_q;
		rx_d     = rx_q;
		crc_d    = crc_q;
		pres_d   = pres_q;
		bus_d    = bus_q;
		res_d    = res_q;
		status   = ST_NO_START;
		done     = 1'b0;
		finish   = 1'b0;

		if (mode != MODE_TICK) begin
			if ((32'(bus_id) >= NUM_BUSES) || !mask4[bus_id]) begin
				status = ST_UNKNOWN;
			end else if (phase_q != PH_IDLE) begin
				status = ST_BUSY;
			end else begin
				status   = ST_OK;
				bus_d    = bus_id;
				kind_d   = mode;
				tx_rom_d = device_rom;
				rx_d     = '0;
				phase_d  = PH_RESET;
				stage_d  = 2'd0;
				bit_d    = 3'd0;
				byte_d   = 4'd0;
				cnt_d    = '0;
				pres_d   = 1'b0;
				crc_d    = 8'd0;
				res_d    = 1'b0;
			end
		end else if (phase_q != PH_IDLE) begin
			if (cnt_q != '0) begin
				cnt_d = cnt_q - TIMER_BITS'(1);
			end else begin
				cnt_d   = field;
				stage_d = last ? 2'd0 : s + 2'd1;
				if (last) begin
					unique case (phase_q)
						PH_RESET: begin
							pres_d = !line_level;
							if (!line_level) begin
								phase_d = PH_WRITE;
							end else begin
								phase_d = PH_IDLE;
								res_d   = 1'b1;
								done    = 1'b1;
							end
						end
						PH_WRITE: begin
							bit_d = bit_q + 3'd1;
							if (wrap) begin
								byte_d = byte_inc;
								if (byte_inc >= send_len(kind_q)) begin
									byte_d = 4'd0;
									if (recv_len(kind_q) != 4'd0)
										phase_d = PH_READ;
									else
										finish = 1'b1;
								end
							end
						end
						default: begin
							if (32'(byte_q) < RX_BYTES)
								rx_d[rx_pos] = line_level;
							if (32'(byte_q) < CRC_BYTES)
								crc_d = crc_bit(crc_q, line_level);
							bit_d = bit_q + 3'd1;
							if (wrap) begin
								byte_d = byte_inc;
								if (byte_inc >= recv_len(kind_q)) begin
									byte_d = 4'd0;
									finish = 1'b1;
								end
							end
						end
					endcase
				end
			end
		end

		if (finish) begin
			phase_d = PH_IDLE;
			res_d   = 1'b0;
			done    = 1'b1;
		end
	end

	// raw * 10 / 16, truncated toward zero
	assign raw      = signed'(rx_d[15:0]);
	assign p10      = (20'(raw) <<< 3) + (20'(raw) <<< 1);
	assign pb       = p10 + (p10[19] ? 20'sd15 : 20'sd0);
	assign t_scaled = 16'(pb >>> 4);

	always_comb begin
		srom_d = srom_q;
		temp_d = temp_q;
		tok_d  = tok_q;
		if (finish) begin
			if (kind_q == MODE_READ_ROM) begin
				srom_d = rx_d[63:0];
			end else if (kind_q == MODE_READ_T) begin
				if (rx_d[71:64] == crc_d) begin
					temp_d = t_scaled;
					tok_d  = 1'b1;
				end else begin
					tok_d  = 1'b0;
				end
			end
		end
	end

	assign tx_byte = send_byte(kind_d, tx_rom_d, byte_d);

	always_comb begin
		rsp.line_release = 1'b1;
		if (stage_d == 2'd1 && phase_d != PH_IDLE)
			rsp.line_release = 1'b0;
		else if (phase_d == PH_WRITE && stage_d == 2'd2)
			rsp.line_release = tx_byte[bit_d];
		rsp.active_bus              = bus_d;
		rsp.busy_res                = (phase_d != PH_IDLE);
		rsp.start_status            = status;
		rsp.transfer_done           = done;
		rsp.device_present          = pres_d;
		rsp.last_result             = res_d;
		rsp.temperature_decidegrees = signed'(temp_d);
		rsp.temperature_valid       = tok_d;
		rsp.rom_code                = srom_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			stage_q <= 2'd0;
			bit_q   <= 3'd0;
			byte_q  <= 4'd0;
			cnt_q   <= '0;
			kind_q  <= 2'd0;
			rx_q    <= '0;
			crc_q   <= 8'd0;
			pres_q  <= 1'b0;
			bus_q   <= 2'd0;
			srom_q  <= 64'd0;
			temp_q  <= 16'd0;
			tok_q   <= 1'b0;
			res_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			stage_q <= stage_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			cnt_q   <= cnt_d;
			kind_q  <= kind_d;
			rx_q    <= rx_d;
			crc_q   <= crc_d;
			pres_q  <= pres_d;
			bus_q   <= bus_d;
			srom_q  <= srom_d;
			temp_q  <= temp_d;
			tok_q   <= tok_d;
			res_q   <= res_d;
		end
	end

	// command bytes are rebuilt from the kind and this address
	always_ff @(posedge clk) begin
		if (step)
			tx_rom_q <= tx_rom_d;
	end

endmodule

/* design/onewire_master_sequencer.sv */
// ----------------------------------------------------------------------------
// onewire_master_sequencer
// 1-Wire bus master advanced by tick items, with start, busy and result
// reporting per beat.
// ----------------------------------------------------------------------------
// Every accepted beat yields exactly one result beat. A beat is captured in an
// input register, stepped through the sequencer and lands in the result
// register, and a new beat is taken every cycle while the result channel is
// ready; the rate is set by the step of the sequencer state. While a result
// waits to be taken, the input register takes a beat only if it is empty, so
// intake stops once both registers are full. Configuration writes take effect on
// the next cycle and are meant for idle periods.
module onewire_master_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	omws_in_if.sink                        items,
	omws_out_if.source                     results,
	input  logic                           wr_en,
	input  logic [1:0]                     wr_index,
	input  logic [omws_pkg::TREG_BITS-1:0] wr_data
);
	import omws_pkg::*;

	cfg_t        cfg;
	result_t     rsp;
	result_t     rsp_s2;
	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [1:0]  bus_s1;
	logic        line_s1;
	logic [63:0] rom_s1;
	logic        valid_s2;
	logic        step;

	assign step        = valid_s1 && (!valid_s2 || results.ready);
	assign items.ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (items.ready)
				valid_s1 <= items.valid;
			if (step)
				valid_s2 <= 1'b1;
			else if (results.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			mode_s1 <= items.mode;
			bus_s1  <= items.bus_id;
			line_s1 <= items.line_level;
			rom_s1  <= items.device_rom;
		end
		if (step)
			rsp_s2 <= rsp;
	end

	omws_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	omws_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.mode       (mode_s1),
		.bus_id     (bus_s1),
		.line_level (line_s1),
		.device_rom (rom_s1),
		.cfg        (cfg),
		.rsp        (rsp)
	);

	assign results.valid                   = valid_s2;
	assign results.line_release            = rsp_s2.line_release;
	assign results.active_bus              = rsp_s2.active_bus;
	assign results.busy_res                = rsp_s2.busy_res;
	assign results.start_status            = rsp_s2.start_status;
	assign results.transfer_done           = rsp_s2.transfer_done;
	assign results.device_present          = rsp_s2.device_present;
	assign results.last_result             = rsp_s2.last_result;
	assign results.temperature_decidegrees = rsp_s2.temperature_decidegrees;
	assign results.temperature_valid       = rsp_s2.temperature_valid;
	assign results.rom_code                = rsp_s2.rom_code;

endmodule

/* design/omws_checker.sv */
// ----------------------------------------------------------------------------
// omws_checker
// Port-level checks of the sequencer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module omws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        line_release,
	input logic        busy_res,
	input logic [1:0]  start_status,
	input logic        transfer_done,
	input logic        device_present,
	input logic        last_result,
	input logic [63:0] rom_code
);
	import omws_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rom_code) && $stable(start_status))
		else $error("result beat dropped or changed while stalled");

	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> line_release)
		else $error("line driven low while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transfer_done |-> !busy_res && start_status == ST_NO_START)
		else $error("transfer end reported while still busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_status == ST_OK |-> busy_res && !device_present && !last_result)
		else $error("accepted start did not open a transfer");

endmodule

bind onewire_master_sequencer omws_checker u_omws_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (results.valid),
	.out_ready      (results.ready),
	.line_release   (results.line_release),
	.busy_res       (results.busy_res),
	.start_status   (results.start_status),
	.transfer_done  (results.transfer_done),
	.device_present (results.device_present),
	.last_result    (results.last_result),
	.rom_code       (results.rom_code)
);
